// File: rtl/spq_pkg.sv
// Shared types and codes for the stable priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   typedef enum logic [1:0] {
      STAT_ENQUEUED = 2'd0,
      STAT_DEQUEUED = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_FULL     = 2'd3
   } stat_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_HOLD = 1'b1
   } fsm_type;

   typedef struct packed {
      logic     load;
      logic     push;
      logic     pop;
      stat_type status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dp_stat_type;

endpackage

// File: rtl/spq_ctrl.sv
// Handshake controller: accepts request words, issues push/pop/load commands.
// Depends on spq_pkg.
module spq_ctrl
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type dp_stat,
   output cmd_type     cmd
);

   fsm_type state_ff;
   fsm_type state_in;
   logic    accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) state_in = FSM_HOLD;
         end
         FSM_HOLD: begin
            if (accept) begin
               state_in = FSM_HOLD;
            end else if (rsp_ready) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
         end
         FSM_HOLD: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.load = accept;
      if (req_mode == MODE_DEQ) begin
         cmd.status = dp_stat.empty ? STAT_EMPTY : STAT_DEQUEUED;
         cmd.push   = 1'b0;
         cmd.pop    = accept && !dp_stat.empty;
      end else begin
         cmd.status = dp_stat.full ? STAT_FULL : STAT_ENQUEUED;
         cmd.push   = accept && !dp_stat.full;
         cmd.pop    = 1'b0;
      end
   end

endmodule

// File: rtl/spq_dp.sv
// Sorted entry array with parallel compare-and-shift, fill count, result register.
// Depends on spq_pkg.
module spq_dp
   import spq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output dp_stat_type        dp_stat,
   input  logic signed [31:0] data_in,
   input  logic        [7:0]  priority_in,
   output logic        [1:0]  rsp_status,
   output logic signed [31:0] rsp_data_out,
   output logic        [7:0]  rsp_priority_out,
   output logic [CNT_W-1:0]   rsp_occupancy
);

   logic signed [31:0] data_ff [DEPTH];
   logic        [7:0]  prio_ff [DEPTH];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [DEPTH-1:0]   ahead;
   logic [1:0]         status_ff;
   logic signed [31:0] dout_ff;
   logic        [7:0]  pout_ff;
   logic [CNT_W-1:0]   occ_ff;

   assign dp_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign dp_stat.empty = (count_ff == '0);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ahead[i] = (CNT_W'(i) < count_ff) && (prio_ff[i] >= priority_in);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_slot
      always_ff @(posedge clock) begin
         if (cmd.push && !ahead[gi]) begin
            if (gi == 0) begin
               data_ff[gi] <= data_in;
               prio_ff[gi] <= priority_in;
            end else if (ahead[(gi == 0) ? 0 : gi - 1]) begin
               data_ff[gi] <= data_in;
               prio_ff[gi] <= priority_in;
            end else begin
               data_ff[gi] <= data_ff[(gi == 0) ? 0 : gi - 1];
               prio_ff[gi] <= prio_ff[(gi == 0) ? 0 : gi - 1];
            end
         end else if (cmd.pop && (gi < DEPTH - 1)) begin
            data_ff[gi] <= data_ff[(gi < DEPTH - 1) ? gi + 1 : gi];
            prio_ff[gi] <= prio_ff[(gi < DEPTH - 1) ? gi + 1 : gi];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= cmd.status;
         occ_ff    <= count_in;
         if (cmd.pop) begin
            dout_ff <= data_ff[0];
            pout_ff <= prio_ff[0];
         end else begin
            dout_ff <= '0;
            pout_ff <= '0;
         end
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_data_out     = dout_ff;
   assign rsp_priority_out = pout_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

// File: rtl/stable_priority_queue_core.sv
// Stable bounded priority queue, top level.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
// Request channel (req_): mode 0 inserts req_data_in at req_priority_in behind
// every held entry of equal or higher priority; mode 1 removes the head.
// Response channel (rsp_): one word per request with status (enqueued,
// dequeued, empty, full refused), the removed data and priority on a
// successful dequeue (zero otherwise) and the occupancy after the request.
// The response is valid in the cycle after the request is taken.
// Throughput: one request per cycle while rsp_ready is high; each insert or remove is
// done by comparing all DEPTH slots at once and shifting the array by one.
// A single output register holds the response; while it waits and rsp_ready
// is low, req_ready is low. A new request is taken in the cycle its
// predecessor's response is taken.
// Reset empties the queue and drops any pending response; the entry storage
// itself is not cleared.
module stable_priority_queue_core
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic signed [31:0]             req_data_in,
   input  logic        [7:0]              req_priority_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic        [1:0]              rsp_status,
   output logic signed [31:0]             rsp_data_out,
   output logic        [7:0]              rsp_priority_out,
   output logic [$clog2(DEPTH + 1)-1:0]   rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type     cmd;
   dp_stat_type dp_stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   spq_dp #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .dp_stat          (dp_stat),
      .data_in          (req_data_in),
      .priority_in      (req_priority_in),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .rsp_priority_out (rsp_priority_out),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule
